// ----- design/mfs_pkg.sv -----
// Shared types and constants for the maximum-frequency stack.
`timescale 1ns / 1ps
package mfs_pkg;

   localparam int ENTRY_CAPACITY_DEF    = 256;
   localparam int DISTINCT_CAPACITY_DEF = 256;
   localparam int VALUE_W               = 32;
   localparam int STATUS_W              = 2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_STORE_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd3;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN,
      OP_PUSH_A,
      OP_PUSH_B,
      OP_POP_TOP,
      OP_POP_A,
      OP_POP_B,
      OP_DEC,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [STATUS_W-1:0]   status;
   } cmd_type;

   typedef struct packed {
      logic is_pop;
      logic store_full;
      logic stack_empty;
      logic scan_done;
      logic slot_found;
      logic slot_free;
   } stat_type;

endpackage

// ----- design/mfs_datapath.sv -----
// Datapath: count table, entry cells, level stacks and result register.
`timescale 1ns / 1ps
module mfs_datapath #(
   parameter int ENTRY_CAPACITY    = mfs_pkg::ENTRY_CAPACITY_DEF,
   parameter int DISTINCT_CAPACITY = mfs_pkg::DISTINCT_CAPACITY_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  mfs_pkg::cmd_type                             cmd,
   output mfs_pkg::stat_type                            stat,
   input  logic                                         req_type,
   input  logic [mfs_pkg::VALUE_W-1:0]                  push_value,
   output logic [mfs_pkg::VALUE_W-1:0]                  popped_value,
   output logic [$clog2(ENTRY_CAPACITY+1)-1:0]          popped_level,
   output logic [mfs_pkg::STATUS_W-1:0]                 status
);
   import mfs_pkg::*;

   localparam int EIW = $clog2(ENTRY_CAPACITY);
   localparam int LW  = $clog2(ENTRY_CAPACITY + 1);
   localparam int DIW = $clog2(DISTINCT_CAPACITY);
   localparam logic [DIW:0]   D_NUM  = (DIW+1)'(DISTINCT_CAPACITY);
   localparam logic [DIW-1:0] D_LAST = DIW'(DISTINCT_CAPACITY - 1);
   localparam logic [LW-1:0]  E_NUM  = LW'(ENTRY_CAPACITY);
   localparam logic [LW-1:0]  ONE    = LW'(1);

   // Memories.
   logic [VALUE_W-1:0] key_mem   [DISTINCT_CAPACITY];
   logic [LW-1:0]      cnt_mem   [DISTINCT_CAPACITY];
   logic [VALUE_W-1:0] value_mem [ENTRY_CAPACITY];
   logic [LW-1:0]      link_mem  [ENTRY_CAPACITY];
   logic [EIW-1:0]     top_mem   [ENTRY_CAPACITY];

   logic [VALUE_W-1:0] key_rd_ff, value_rd_ff;
   logic [LW-1:0]      cnt_rd_ff, link_rd_ff;
   logic [EIW-1:0]     top_rd_ff;

   logic [DISTINCT_CAPACITY-1:0] used_ff;
   logic [LW-1:0]  free_head_ff, top_level_ff, total_ff, fresh_ff;
   logic [VALUE_W-1:0] val_ff;
   logic           is_pop_ff;

   // Scan state.
   logic [DIW:0]   issue_ff;
   logic           cmp_vld_ff;
   logic [DIW-1:0] cmp_idx_ff;
   logic           done_ff, found_ff, free_ff;
   logic [DIW-1:0] slot_ff, free_slot_ff;
   logic [LW-1:0]  cnt_ff, lvl_ff;
   logic [EIW-1:0] cell_ff;
   logic [VALUE_W-1:0] pop_value_ff;
   logic [LW-1:0]  pop_level_ff;

   logic [VALUE_W-1:0] rsp_value_ff;
   logic [LW-1:0]      rsp_level_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // Combinational helpers.
   logic           key_we, cnt_we, link_we, value_we, top_we;
   logic [DIW-1:0] key_wa, key_ra;
   logic [VALUE_W-1:0] key_wd;
   logic [LW-1:0]  cnt_wd;
   logic [EIW-1:0] link_wa, link_ra, top_wa, top_ra;
   logic [LW-1:0]  link_wd;
   logic [EIW-1:0] top_wd;
   logic [DIW-1:0] use_slot;
   logic [LW-1:0]  use_cnt, new_lvl;
   logic [EIW-1:0] head_cell;

   assign use_slot  = found_ff ? slot_ff : free_slot_ff;
   assign use_cnt   = found_ff ? cnt_ff : '0;
   assign new_lvl   = use_cnt + ONE;
   assign head_cell = free_head_ff[EIW-1:0];

   always_comb begin
      key_we   = 1'b0;
      cnt_we   = 1'b0;
      link_we  = 1'b0;
      value_we = 1'b0;
      top_we   = 1'b0;
      key_wa   = use_slot;
      key_wd   = val_ff;
      cnt_wd   = new_lvl;
      key_ra   = issue_ff[DIW-1:0];
      link_wa  = cell_ff;
      link_wd  = free_head_ff;
      link_ra  = head_cell;
      top_wa   = EIW'(lvl_ff - ONE);
      top_wd   = cell_ff;
      top_ra   = use_cnt[EIW-1:0];
      unique case (cmd.op)
         OP_PUSH_A: begin
            key_we = 1'b1;
            cnt_we = 1'b1;
         end
         OP_PUSH_B: begin
            value_we = 1'b1;
            link_we  = 1'b1;
            top_we   = 1'b1;
            top_wa   = EIW'(lvl_ff - ONE);
            link_wd  = (lvl_ff > top_level_ff) ? LW'(cell_ff) : LW'(top_rd_ff);
         end
         OP_POP_TOP: top_ra = EIW'(top_level_ff - ONE);
         OP_POP_A:   link_ra = top_rd_ff;
         OP_POP_B: begin
            link_we = 1'b1;
            link_wd = free_head_ff;
            top_we  = (link_rd_ff != LW'(cell_ff));
            top_wa  = EIW'(top_level_ff - ONE);
            top_wd  = link_rd_ff[EIW-1:0];
         end
         OP_DEC: begin
            cnt_we = 1'b1;
            key_wa = slot_ff;
            cnt_wd = cnt_ff - ONE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_wa] <= key_wd;
      key_rd_ff <= key_mem[key_ra];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[key_wa] <= cnt_wd;
      cnt_rd_ff <= cnt_mem[key_ra];
   end

   always_ff @(posedge clock) begin
      if (value_we) value_mem[cell_ff] <= val_ff;
      value_rd_ff <= value_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
      link_rd_ff <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (top_we) top_mem[top_wa] <= top_wd;
      top_rd_ff <= top_mem[top_ra];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         free_head_ff <= '0;
         top_level_ff <= '0;
         total_ff     <= '0;
         fresh_ff     <= '0;
         done_ff      <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         issue_ff     <= '0;
      end else begin
         unique case (cmd.op) inside
            OP_LOAD, OP_POP_B: begin
               done_ff    <= 1'b0;
               found_ff   <= 1'b0;
               free_ff    <= 1'b0;
               cmp_vld_ff <= 1'b0;
               issue_ff   <= '0;
            end
            OP_SCAN: begin
               cmp_vld_ff <= (issue_ff != D_NUM);
               if (issue_ff != D_NUM) issue_ff <= issue_ff + 1'b1;
            end
            default: ;
         endcase
         if (cmd.op == OP_SCAN && cmp_vld_ff && !done_ff) begin
            if (used_ff[cmp_idx_ff] && key_rd_ff == val_ff) begin
               found_ff <= 1'b1;
               done_ff  <= 1'b1;
            end else if (cmp_idx_ff == D_LAST) begin
               done_ff <= 1'b1;
            end
            if (!used_ff[cmp_idx_ff]) free_ff <= 1'b1;
         end
         unique case (cmd.op)
            OP_PUSH_A: used_ff[use_slot] <= 1'b1;
            OP_PUSH_B: begin
               total_ff <= total_ff + ONE;
               if (free_head_ff == fresh_ff) begin
                  free_head_ff <= fresh_ff + ONE;
                  fresh_ff     <= fresh_ff + ONE;
               end else begin
                  free_head_ff <= link_rd_ff;
               end
               if (lvl_ff > top_level_ff) top_level_ff <= lvl_ff;
            end
            OP_POP_B: begin
               free_head_ff <= LW'(cell_ff);
               total_ff     <= total_ff - ONE;
               if (link_rd_ff == LW'(cell_ff)) top_level_ff <= top_level_ff - ONE;
            end
            OP_DEC: if (cnt_ff == ONE) used_ff[slot_ff] <= 1'b0;
            default: ;
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         val_ff    <= push_value;
         is_pop_ff <= req_type;
      end
      if (cmd.op == OP_SCAN) cmp_idx_ff <= issue_ff[DIW-1:0];
      if (cmd.op == OP_SCAN && cmp_vld_ff && !done_ff) begin
         if (used_ff[cmp_idx_ff] && key_rd_ff == val_ff) begin
            slot_ff <= cmp_idx_ff;
            cnt_ff  <= cnt_rd_ff;
         end
         if (!used_ff[cmp_idx_ff] && !free_ff) free_slot_ff <= cmp_idx_ff;
      end
      if (cmd.op == OP_PUSH_A) begin
         lvl_ff  <= new_lvl;
         cell_ff <= head_cell;
      end
      if (cmd.op == OP_POP_A) cell_ff <= top_rd_ff;
      if (cmd.op == OP_POP_B) begin
         val_ff       <= value_rd_ff;
         pop_value_ff <= value_rd_ff;
         pop_level_ff <= top_level_ff;
      end
      if (cmd.op == OP_RESULT) begin
         rsp_status_ff <= cmd.status;
         rsp_value_ff  <= (is_pop_ff && cmd.status == ST_OK) ? pop_value_ff : '0;
         rsp_level_ff  <= (is_pop_ff && cmd.status == ST_OK) ? pop_level_ff : '0;
      end
   end

   assign stat.is_pop      = is_pop_ff;
   assign stat.store_full  = (total_ff == E_NUM);
   assign stat.stack_empty = (top_level_ff == '0);
   assign stat.scan_done   = done_ff;
   assign stat.slot_found  = found_ff;
   assign stat.slot_free   = free_ff;

   assign popped_value = rsp_value_ff;
   assign popped_level = rsp_level_ff;
   assign status       = rsp_status_ff;

endmodule

// ----- design/mfs_control.sv -----
// Controller: sequences each request through the datapath.
`timescale 1ns / 1ps
module mfs_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  mfs_pkg::stat_type  stat,
   output mfs_pkg::cmd_type   cmd
);
   import mfs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_POP_TOP, S_POP_A, S_POP_B,
      S_SCAN, S_PUSH_A, S_PUSH_B, S_DEC, S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = OP_NONE;
      cmd.status   = status_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) begin
            cmd.op   = OP_LOAD;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            if (stat.is_pop) begin
               if (stat.stack_empty) begin
                  status_in = ST_POP_EMPTY;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_POP_TOP;
               end
            end else if (stat.store_full) begin
               status_in = ST_STORE_FULL;
               state_in  = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_POP_TOP: begin
            cmd.op   = OP_POP_TOP;
            state_in = S_POP_A;
         end
         S_POP_A: begin
            cmd.op   = OP_POP_A;
            state_in = S_POP_B;
         end
         S_POP_B: begin
            cmd.op   = OP_POP_B;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (stat.scan_done) begin
               if (stat.is_pop) begin
                  state_in = S_DEC;
               end else if (stat.slot_found || stat.slot_free) begin
                  state_in = S_PUSH_A;
               end else begin
                  status_in = ST_TABLE_FULL;
                  state_in  = S_DONE;
               end
            end
         end
         S_PUSH_A: begin
            cmd.op   = OP_PUSH_A;
            state_in = S_PUSH_B;
         end
         S_PUSH_B: begin
            cmd.op    = OP_PUSH_B;
            status_in = ST_OK;
            state_in  = S_DONE;
         end
         S_DEC: begin
            cmd.op    = OP_DEC;
            status_in = ST_OK;
            state_in  = S_DONE;
         end
         S_DONE: if (out_free) begin
            cmd.op       = OP_RESULT;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/max_frequency_stack_unit.sv -----
// Top level of the maximum-frequency stack: controller plus datapath.
//
//   Channel | Direction | tdata                          | tuser
//   req_    | in        | push_value[31:0]               | req_type[0]
//   rsp_    | out       | popped_value, popped_level     | status[1:0]
//
// Every word is matched against the distinct-value table one slot per cycle, and the
// scan stops early when the value is found; a pop first does three level and cell reads.
// Pushes into a full entry store and pops of an empty stack answer without a scan.
// Reset is synchronous and active high; it empties the stack at once, with no clearing
// pass. A new word is taken while a result waits on rsp_; the next one is held till then.
`timescale 1ns / 1ps
module max_frequency_stack_unit #(
   parameter int ENTRY_CAPACITY    = mfs_pkg::ENTRY_CAPACITY_DEF,
   parameter int DISTINCT_CAPACITY = mfs_pkg::DISTINCT_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // push_value[31:0]
   input  logic [mfs_pkg::VALUE_W-1:0] req_tdata,
   // req_type[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // popped_value[31:0], popped_level above it, zero padding to whole bytes
   output logic [((mfs_pkg::VALUE_W + $clog2(ENTRY_CAPACITY+1) + 7) / 8) * 8 - 1:0]
                       rsp_tdata,
   // status[1:0]
   output logic [mfs_pkg::STATUS_W-1:0] rsp_tuser
);
   import mfs_pkg::*;

   localparam int LW     = $clog2(ENTRY_CAPACITY + 1);
   localparam int DATA_W = ((VALUE_W + LW + 7) / 8) * 8;

   cmd_type             cmd;
   stat_type            stat;
   logic [VALUE_W-1:0]  popped_value;
   logic [LW-1:0]       popped_level;

   mfs_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mfs_datapath #(
      .ENTRY_CAPACITY    (ENTRY_CAPACITY),
      .DISTINCT_CAPACITY (DISTINCT_CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_type     (req_tuser[0]),
      .push_value   (req_tdata),
      .popped_value (popped_value),
      .popped_level (popped_level),
      .status       (rsp_tuser)
   );

   // Padding bits are constant zero.
   assign rsp_tdata = DATA_W'({popped_level, popped_value});

`ifndef SYNTHESIS
   // A failed request never carries a value or a level.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == '0)
      else $error("error result carries data");

   // The sequencer never takes two words in back-to-back cycles.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("word accepted while busy");

   // A full entry store always has a non-empty stack.
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      stat.store_full |-> !stat.stack_empty)
      else $error("full store with empty stack");
`endif

endmodule

// ----- verif/max_frequency_stack_checker.sv -----
// Checker for the maximum-frequency stack: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module max_frequency_stack_checker #(
   parameter int ENTRY_CAPACITY    = mfs_pkg::ENTRY_CAPACITY_DEF,
   parameter int DISTINCT_CAPACITY = mfs_pkg::DISTINCT_CAPACITY_DEF,
   parameter int RSP_W             = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [mfs_pkg::VALUE_W-1:0]   req_tdata,
   input  logic [0:0]                    req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [RSP_W-1:0]              rsp_tdata,
   input  logic [mfs_pkg::STATUS_W-1:0]  rsp_tuser,
   output int                            fail_count,
   output int                            outstanding
);
   import mfs_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [8:0]          level;
      logic [STATUS_W-1:0] status;
   } pop_result_type;

   // Occurrence counts per value and one stack of values per count level.
   int unsigned           occurrences[bit [VALUE_W-1:0]];
   bit [VALUE_W-1:0]      level_stack[int][$];
   int unsigned           highest_level;
   int unsigned           stored_words;
   pop_result_type        awaited_results[$];

   function automatic pop_result_type apply_request(logic is_pop, logic [VALUE_W-1:0] v);
      pop_result_type r;
      r = '0;
      if (is_pop == REQ_PUSH) begin
         if (stored_words >= ENTRY_CAPACITY) begin
            r.status = ST_STORE_FULL;
         end else if (!occurrences.exists(v) && occurrences.num() >= DISTINCT_CAPACITY) begin
            r.status = ST_TABLE_FULL;
         end else begin
            if (!occurrences.exists(v)) occurrences[v] = 0;
            occurrences[v]++;
            level_stack[occurrences[v]].insert(level_stack[occurrences[v]].size(), v);
            if (occurrences[v] > highest_level) highest_level = occurrences[v];
            stored_words++;
            r.status = ST_OK;
         end
      end else if (highest_level == 0) begin
         r.status = ST_POP_EMPTY;
      end else begin
         // The most recent push at the highest level wins ties.
         r.value  = level_stack[highest_level][$];
         level_stack[highest_level].delete(level_stack[highest_level].size() - 1);
         r.level  = highest_level[8:0];
         r.status = ST_OK;
         if (level_stack[highest_level].size() == 0) highest_level--;
         stored_words--;
         occurrences[r.value]--;
         if (occurrences[r.value] == 0) occurrences.delete(r.value);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      fail_count++;
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
   endtask

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      highest_level = 0;
      stored_words  = 0;
   end

   always @(posedge clock) begin
      pop_result_type want;
      if (!reset) begin
         // Results are checked before the new request is predicted; a word
         // taken on this edge can never be answered on the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata, 0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_tdata[31:0] !== want.value)
                  report_mismatch("popped_value", rsp_tdata[31:0], want.value);
               if (rsp_tdata[40:32] !== want.level)
                  report_mismatch("popped_level", rsp_tdata[40:32], want.level);
               if (rsp_tdata[RSP_W-1:41] !== '0)
                  report_mismatch("padding", rsp_tdata[RSP_W-1:41], 0);
               if (rsp_tuser !== want.status)
                  report_mismatch("status", rsp_tuser, want.status);
            end
         end
         if (req_tvalid && req_tready)
            awaited_results.insert(awaited_results.size(),
                                   apply_request(req_tuser[0], req_tdata));
         outstanding = awaited_results.size();
      end
   end

endmodule

// ----- verif/max_frequency_stack_unit_tb.sv -----
// Testbench top for the maximum-frequency stack: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module max_frequency_stack_unit_tb;
   import mfs_pkg::*;

   localparam int RSP_W       = ((VALUE_W + $clog2(ENTRY_CAPACITY_DEF + 1) + 7) / 8) * 8;
   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 300;
   localparam int HOLD_CYCLES = 800;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [VALUE_W-1:0]     req_tdata = '0;
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;

   int  fail_count;
   int  outstanding;
   int  idle_cycles = 0;
   bit  no_gaps = 0;        // When set, neither side idles.
   bit  hold_receiver = 0;  // Asks the receiver for one long stall.
   bit  [VALUE_W-1:0] value_pool[8];

   max_frequency_stack_unit u_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   max_frequency_stack_checker #(.RSP_W(RSP_W)) u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .outstanding
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog: a long run of cycles with no word moving on either side is a hang.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one word. Valid stays high across back-to-back words, so it is only
   // lowered when a gap is actually taken.
   task automatic send_request(logic is_pop, logic [VALUE_W-1:0] v);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= is_pop;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic push_value(logic [VALUE_W-1:0] v);
      send_request(REQ_PUSH, v);
   endtask

   // A pop carries random data, which the block must ignore.
   task automatic pop_value();
      send_request(REQ_POP, $urandom);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9)) inside
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom;
         default: return value_pool[$urandom_range(0, 7)];
      endcase
   endfunction

   // Receiver: stalls a random number of cycles before each word, or holds off
   // for a long stretch when asked so the block backs up into its input.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_receiver) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_receiver = 0;
         end else begin
            gap = no_gaps ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int push_pct;
      for (int i = 0; i < 8; i++) value_pool[i] = $urandom;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: pop on empty, extreme values, ties and data ignored on pops.
      pop_value();
      push_value('0);
      push_value('1);
      push_value(32'h5555_5555);
      push_value('1);
      push_value(32'hAAAA_AAAA);
      pop_value();
      pop_value();
      pop_value();
      pop_value();
      pop_value();
      pop_value();

      // One value pushed until the highest level is reached, then drained.
      no_gaps = 1;
      repeat (ENTRY_CAPACITY_DEF) push_value(32'h8000_0001);
      push_value(32'h8000_0001);
      repeat (ENTRY_CAPACITY_DEF + 1) pop_value();
      no_gaps = 0;

      // Fill the entry store with mostly distinct values, overflow it, then empty it.
      // The long receiver stall lands during the fill.
      for (int i = 0; i < ENTRY_CAPACITY_DEF; i++) begin
         if (i == 40) hold_receiver = 1;
         push_value((i % 3 == 0) ? value_pool[i % 8] : $urandom);
      end
      push_value($urandom);
      push_value(value_pool[0]);
      repeat (ENTRY_CAPACITY_DEF + 1) pop_value();

      // Random chunks with a shifting push bias, drawn mostly from a small pool
      // so that counts climb and ties are common.
      for (int chunk = 0; chunk < 3; chunk++) begin
         push_pct = $urandom_range(30, 85);
         no_gaps  = ($urandom_range(0, 3) == 0);
         repeat (40) begin
            if ($urandom_range(1, 100) <= push_pct) push_value(pick_value());
            else pop_value();
         end
      end
      no_gaps = 0;
      req_tvalid <= 1'b0;

      // One more edge so the checker has recorded the last word.
      @(posedge clock);
      wait (outstanding == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
